/* sv/bfiq_pkg.sv */
// Shared constants, command and status types and helpers for the Bloom filter block.
`timescale 1ns / 1ps

package bfiq_pkg;

    localparam int MAX_FILTER_BYTES = 512;
    localparam int MAX_PROBES       = 30;
    localparam int FILTER_CAP       = MAX_FILTER_BYTES * 8;
    localparam int MIN_FILTER_BITS  = 64;
    localparam int POS_W            = $clog2(FILTER_CAP);
    localparam int BYTE_AW          = $clog2(MAX_FILTER_BYTES);
    localparam int BITS_W           = 13;
    localparam int BITS_EXT_W       = BITS_W + 1;
    localparam int PROBE_W          = 5;
    localparam int HASH_W           = 32;
    localparam int ROT              = 17;
    localparam int RADIX_BITS       = 4;
    localparam int MOD_STEPS        = HASH_W / RADIX_BITS;
    localparam int MOD_CNT_W        = $clog2(MOD_STEPS);
    localparam int CFG_IDX_W        = 8;
    localparam int CFG_DATA_W       = 13;
    localparam int OUT_W            = 8;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_PROBES  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_BITS = CFG_IDX_W'(1);

    localparam logic [PROBE_W-1:0] NUM_PROBES_RST  = PROBE_W'(6);
    localparam logic [BITS_W-1:0]  FILTER_BITS_RST = BITS_W'(4096);
    localparam logic [PROBE_W-1:0] PROBE_LIMIT     = PROBE_W'(MAX_PROBES);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // Which dividend the remainder unit works on.
    typedef enum logic [1:0] {
        MOD_HASH = 2'd0,
        MOD_STEP = 2'd1,
        MOD_WRAP = 2'd2
    } bfiq_mod_sel_t;

    typedef struct packed {
        logic          load_item;
        logic          clear_wr;
        logic          mod_start;
        bfiq_mod_sel_t mod_sel;
        logic          cap_pos;
        logic          cap_step;
        logic          cap_wrap;
        logic          mem_rd;
        logic          probe_commit;
        logic          miss;
        logic          out_load;
    } bfiq_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic skip_probes;
        logic mod_done;
        logic is_query;
        logic bit_set;
        logic last_probe;
        logic out_free;
    } bfiq_sts_t;

    // Filter size actually used: at least 64, rounded up to a byte, capped at the store.
    function automatic logic [BITS_W-1:0] bits_in_use(input logic [BITS_W-1:0] fb);
        logic [BITS_EXT_W-1:0] b;
        b = {1'b0, fb};
        if (b < BITS_EXT_W'(MIN_FILTER_BITS)) begin
            b = BITS_EXT_W'(MIN_FILTER_BITS);
        end
        b = (b + BITS_EXT_W'(7)) & ~BITS_EXT_W'(7);
        if (b > BITS_EXT_W'(FILTER_CAP)) begin
            b = BITS_EXT_W'(FILTER_CAP);
        end
        return b[BITS_W-1:0];
    endfunction

    // Probe step: the hash rotated right.
    function automatic logic [HASH_W-1:0] probe_step(input logic [HASH_W-1:0] h);
        return {h[ROT-1:0], h[HASH_W-1:ROT]};
    endfunction

endpackage

/* sv/bfiq_mod.sv */
// Iterative remainder unit: 32-bit dividend modulo the filter size, four bits per cycle.
`timescale 1ns / 1ps

module bfiq_mod (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [bfiq_pkg::HASH_W-1:0]  dividend,
    input  logic [bfiq_pkg::BITS_W-1:0]  divisor,
    output logic [bfiq_pkg::POS_W-1:0]   rem,
    output logic                         done
);
    import bfiq_pkg::*;

    logic [HASH_W-1:0]    dvd_reg, dvd_next;
    logic [POS_W-1:0]     rem_reg, rem_next;
    logic [MOD_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    // Four restoring steps per cycle on the partial remainder.
    always_comb begin
        logic [BITS_W-1:0] t;
        logic [POS_W-1:0]  r;
        r = rem_reg;
        for (int i = 0; i < RADIX_BITS; i++) begin
            t = BITS_W'({r, dvd_reg[HASH_W-1-i]});
            if (t >= divisor) begin
                t = t - divisor;
            end
            r = t[POS_W-1:0];
        end

        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = dvd_reg << RADIX_BITS;
            rem_next = r;
            cnt_next = cnt_reg + MOD_CNT_W'(1);
            if (cnt_reg == MOD_CNT_W'(MOD_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

/* sv/bfiq_datapath.sv */
// Datapath: configuration registers, probe arithmetic, bit store and result register.
`timescale 1ns / 1ps

module bfiq_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [bfiq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bfiq_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_op,
    input  logic [bfiq_pkg::HASH_W-1:0]     in_key_hash,
    input  bfiq_pkg::bfiq_cmd_t             cmd,
    output bfiq_pkg::bfiq_sts_t             sts,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bfiq_pkg::OUT_W-1:0]      m_tdata
);
    import bfiq_pkg::*;

    logic [PROBE_W-1:0] np_reg;
    logic [BITS_W-1:0]  fb_reg;

    logic [HASH_W-1:0]  h_reg;
    logic [HASH_W-1:0]  step_reg;
    logic               is_query_reg;
    logic               skip_reg;
    logic [BITS_W-1:0]  bits_reg;
    logic [PROBE_W-1:0] k_reg;
    logic [PROBE_W-1:0] j_reg;
    logic               hit_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   s_reg;
    logic [POS_W-1:0]   w_reg;

    logic [BYTE_AW-1:0] clr_cnt_reg;
    logic [7:0]         mem [MAX_FILTER_BYTES];
    logic [7:0]         rdata_reg;

    logic               m_tvalid_reg;
    logic               mp_reg;

    logic [PROBE_W-1:0] k_one;
    logic [HASH_W-1:0]  mod_dvd;
    logic [POS_W-1:0]   mod_rem;
    logic               mod_done;
    logic [BITS_W-1:0]  wrap_cand;
    logic [HASH_W:0]    h_sum;
    logic [BITS_W-1:0]  sum_a;
    logic [BITS_W-1:0]  red_a;
    logic [BITS_W-1:0]  wrap_sum;
    logic [POS_W-1:0]   pos_a;
    logic [POS_W-1:0]   pos_nxt;
    logic [7:0]         bit_mask;
    logic               mem_we;
    logic [BYTE_AW-1:0] mem_waddr;
    logic [7:0]         mem_wdata;

    assign k_one = (np_reg == '0) ? PROBE_W'(1) : np_reg;

    always_comb begin
        case (cmd.mod_sel)
            MOD_HASH: mod_dvd = h_reg;
            MOD_STEP: mod_dvd = step_reg;
            MOD_WRAP: mod_dvd = '1;
            default:  mod_dvd = '0;
        endcase
    end

    bfiq_mod u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.mod_start),
        .dividend (mod_dvd),
        .divisor  (bits_reg),
        .rem      (mod_rem),
        .done     (mod_done)
    );

    // 2^32 mod B is one more than (2^32 - 1) mod B, folded back to zero at B.
    assign wrap_cand = BITS_W'(mod_rem) + BITS_W'(1);

    // Next probe: add the reduced step, and take away 2^32 mod B when the hash wrapped.
    assign h_sum    = {1'b0, h_reg} + {1'b0, step_reg};
    assign sum_a    = BITS_W'(pos_reg) + BITS_W'(s_reg);
    assign red_a    = (sum_a >= bits_reg) ? (sum_a - bits_reg) : sum_a;
    assign pos_a    = red_a[POS_W-1:0];
    assign wrap_sum = BITS_W'(pos_a) + bits_reg - BITS_W'(w_reg);

    always_comb begin
        pos_nxt = pos_a;
        if (h_sum[HASH_W]) begin
            if (pos_a >= w_reg) begin
                pos_nxt = pos_a - w_reg;
            end else begin
                pos_nxt = wrap_sum[POS_W-1:0];
            end
        end
    end

    assign bit_mask  = 8'(1) << pos_reg[2:0];
    assign mem_we    = cmd.clear_wr | (cmd.probe_commit & ~is_query_reg);
    assign mem_waddr = cmd.clear_wr ? clr_cnt_reg : pos_reg[POS_W-1:3];
    assign mem_wdata = cmd.clear_wr ? 8'h00 : (rdata_reg | bit_mask);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.mem_rd) begin
            rdata_reg <= mem[pos_reg[POS_W-1:3]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            np_reg       <= NUM_PROBES_RST;
            fb_reg       <= FILTER_BITS_RST;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we && cfg_index == REG_NUM_PROBES) begin
                np_reg <= cfg_data[PROBE_W-1:0];
            end
            if (cfg_we && cfg_index == REG_FILTER_BITS) begin
                fb_reg <= cfg_data[BITS_W-1:0];
            end
            if (cmd.clear_wr) begin
                clr_cnt_reg <= clr_cnt_reg + BYTE_AW'(1);
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            h_reg        <= in_key_hash;
            step_reg     <= probe_step(in_key_hash);
            is_query_reg <= in_op;
            bits_reg     <= bits_in_use(fb_reg);
            skip_reg     <= (in_op == OP_QUERY) && (k_one > PROBE_LIMIT);
            k_reg        <= ((in_op == OP_INSERT) && (k_one > PROBE_LIMIT)) ? PROBE_LIMIT
                                                                            : k_one;
            j_reg        <= '0;
            hit_reg      <= 1'b1;
        end
        if (cmd.cap_pos) begin
            pos_reg <= mod_rem;
        end
        if (cmd.cap_step) begin
            s_reg <= mod_rem;
        end
        if (cmd.cap_wrap) begin
            w_reg <= (wrap_cand == bits_reg) ? '0 : wrap_cand[POS_W-1:0];
        end
        if (cmd.probe_commit) begin
            pos_reg <= pos_nxt;
            h_reg   <= h_sum[HASH_W-1:0];
            j_reg   <= j_reg + PROBE_W'(1);
        end
        if (cmd.miss) begin
            hit_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            mp_reg <= is_query_reg & hit_reg;
        end
    end

    assign sts.clear_last  = (clr_cnt_reg == '1);
    assign sts.skip_probes = skip_reg;
    assign sts.mod_done    = mod_done;
    assign sts.is_query    = is_query_reg;
    assign sts.bit_set     = rdata_reg[pos_reg[2:0]];
    assign sts.last_probe  = ((j_reg + PROBE_W'(1)) == k_reg);
    assign sts.out_free    = ~m_tvalid_reg | m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_W-1){1'b0}}, mp_reg};

endmodule

/* sv/bfiq_ctrl.sv */
// Controller: sequences the clearing pass, remainder setup and per-probe store accesses.
`timescale 1ns / 1ps

module bfiq_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  bfiq_pkg::bfiq_sts_t  sts,
    output bfiq_pkg::bfiq_cmd_t  cmd
);
    import bfiq_pkg::*;

    typedef enum logic [8:0] {
        ST_CLEAR    = 9'b000000001,
        ST_IDLE     = 9'b000000010,
        ST_SETUP    = 9'b000000100,
        ST_MOD_H    = 9'b000001000,
        ST_MOD_S    = 9'b000010000,
        ST_MOD_W    = 9'b000100000,
        ST_PROBE_RD = 9'b001000000,
        ST_PROBE_WR = 9'b010000000,
        ST_DONE     = 9'b100000000
    } bfiq_state_t;

    bfiq_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mod_sel = MOD_HASH;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_SETUP;
                end
            end
            ST_SETUP: begin
                if (sts.skip_probes) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.mod_start = 1'b1;
                    cmd.mod_sel   = MOD_HASH;
                    state_next    = ST_MOD_H;
                end
            end
            ST_MOD_H: begin
                if (sts.mod_done) begin
                    cmd.cap_pos   = 1'b1;
                    cmd.mod_start = 1'b1;
                    cmd.mod_sel   = MOD_STEP;
                    state_next    = ST_MOD_S;
                end
            end
            ST_MOD_S: begin
                if (sts.mod_done) begin
                    cmd.cap_step  = 1'b1;
                    cmd.mod_start = 1'b1;
                    cmd.mod_sel   = MOD_WRAP;
                    state_next    = ST_MOD_W;
                end
            end
            ST_MOD_W: begin
                if (sts.mod_done) begin
                    cmd.cap_wrap = 1'b1;
                    state_next   = ST_PROBE_RD;
                end
            end
            ST_PROBE_RD: begin
                cmd.mem_rd = 1'b1;
                state_next = ST_PROBE_WR;
            end
            ST_PROBE_WR: begin
                if (sts.is_query && !sts.bit_set) begin
                    cmd.miss   = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    cmd.probe_commit = 1'b1;
                    state_next = sts.last_probe ? ST_DONE : ST_PROBE_RD;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

/* sv/bloom_filter_insert_query_top.sv */
// Top level of the Bloom filter insert and query block.
`timescale 1ns / 1ps
//
// The block keeps a Bloom filter of up to 4096 bits and takes one key word at a time on the
// s_ stream: tdata carries the 32-bit key hash, tuser carries the operation (0 insert,
// 1 query). Every key word produces exactly one result word on the m_ stream; bit 0 of
// m_tdata is the possible-match flag, which is set only for a query whose probe bits are
// all set or whose probe count is past the limit of 30. Inserts always return zero.
// Probe positions come from double hashing: the hash plus multiples of the hash rotated
// right by 17, reduced modulo the filter size in use. A shared remainder unit reduces the
// hash, the step and the 2^32 wrap correction in turn; every insert probe is then a
// read-modify-write of the byte-wide store and every query probe a read of it. A query miss
// ends the probing early, and a query with more than 30 probes skips the remainder unit
// and the probes altogether. The next key can be taken in the cycle after the result is
// loaded; no key is accepted while the previous one is still in flight.
// After reset the block sweeps the 512-byte store to zero, one byte per cycle, and holds
// s_tready low during the sweep; configuration writes are taken throughout.
// The result sits in an output register, so a stalled receiver does not block the next key:
// it is accepted and processed, and only its result waits until the register frees up.
// Configuration writes (index 0 probe count, index 1 filter size) are always ready and
// must only be issued while no key is in flight.

module bloom_filter_insert_query_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Key stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bfiq_pkg::HASH_W-1:0]     s_tdata,   // [31:0] key_hash
    input  logic                            s_tuser,   // [0] op
    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bfiq_pkg::OUT_W-1:0]      m_tdata,   // [0] maybe_present, [7:1] zero
    // Configuration write channel.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bfiq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bfiq_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bfiq_pkg::*;

    bfiq_cmd_t cmd;
    bfiq_sts_t sts;

    // Register writes land directly; the block never needs to hold one off.
    assign cfg_ready = 1'b1;

    bfiq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bfiq_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_valid & cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_op       (s_tuser),
        .in_key_hash (s_tdata),
        .cmd         (cmd),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

/* sv/bfiq_checker.sv */
// Port-level checker for the Bloom filter block and its bind to the top level.
`timescale 1ns / 1ps

module bfiq_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [bfiq_pkg::OUT_W-1:0]  m_tdata
);
    import bfiq_pkg::*;

    // A held result word must not change under backpressure.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // Reset drops the result and starts the clearing sweep, so no key is taken next cycle.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("block not quiet after reset");

    // One key at a time: the cycle after a key is taken the input is closed.
    a_one_key: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second key accepted back to back");

    // Padding bits of the result word stay zero.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[OUT_W-1:1] == '0)
        else $error("result padding not zero");

endmodule

bind bloom_filter_insert_query_top bfiq_checker u_bfiq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
